// ===== hw/rtl/bsrm_pkg.sv =====
`timescale 1ns / 1ps

package bsrm_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] MODE_BUS_WRITE = 2'd0;
  localparam logic [1:0] MODE_PRG_XLATE = 2'd1;
  localparam logic [1:0] MODE_CHR_XLATE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PRG_MASK = 2'd0;
  localparam logic [1:0] REG_CHR_MASK = 2'd1;

  // Bus decode
  localparam logic [15:0] DECODE_MASK  = 16'hE001;
  localparam logic [15:0] ADDR_COMMAND = 16'h8000;
  localparam logic [15:0] ADDR_DATA    = 16'h8001;
  localparam logic [15:0] PRG_BASE     = 16'h8000;
  localparam logic [15:0] CHR_LIMIT    = 16'h2000;

  // Bank commands
  localparam logic [7:0] CMD_CHR01_PAIR = 8'h00;
  localparam logic [7:0] CMD_CHR23_PAIR = 8'h01;
  localparam logic [7:0] CMD_CHR4       = 8'h02;
  localparam logic [7:0] CMD_CHR5       = 8'h03;
  localparam logic [7:0] CMD_CHR6       = 8'h04;
  localparam logic [7:0] CMD_CHR7       = 8'h05;
  localparam logic [7:0] CMD_PRG0       = 8'h06;
  localparam logic [7:0] CMD_PRG1       = 8'h07;
  localparam logic [7:0] CMD_PRG2_ALT   = 8'h46;
  localparam logic [7:0] CMD_PRG1_ALT   = 8'h47;
  localparam logic [7:0] CMD_CHR45_PAIR = 8'h80;
  localparam logic [7:0] CMD_CHR67_PAIR = 8'h81;
  localparam logic [7:0] CMD_CHR0       = 8'h82;
  localparam logic [7:0] CMD_CHR1       = 8'h83;
  localparam logic [7:0] CMD_CHR2       = 8'h84;
  localparam logic [7:0] CMD_CHR3       = 8'h85;

  localparam int PRG_WINDOWS = 4;
  localparam int CHR_WINDOWS = 8;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;  // latch the incoming transfer
    logic execute;  // update bank state and load the result register
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/bsrm_ctrl.sv =====
`timescale 1ns / 1ps

module bsrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bsrm_pkg::ctrl_cmd_t cmd
);
  import bsrm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register free or draining this cycle
        if (!out_valid_r || out_tready) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/bsrm_datapath.sv =====
`timescale 1ns / 1ps

module bsrm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bsrm_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]          in_mode,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  output logic [20:0]         mapped_address,
  output logic                mapped_valid
);
  import bsrm_pkg::*;

  logic [1:0]  mode_r;
  logic [15:0] addr_r;
  logic [7:0]  value_r;

  logic [7:0] prg_mask_r, chr_mask_r;
  logic [7:0] command_r;
  logic [7:0] prg_bank_r [PRG_WINDOWS];
  logic [7:0] prg_bank_nxt [PRG_WINDOWS];
  logic [7:0] chr_bank_r [CHR_WINDOWS];
  logic [7:0] chr_bank_nxt [CHR_WINDOWS];
  logic [7:0] command_nxt;

  logic [20:0] map_addr_r, map_addr_nxt;
  logic        map_valid_r, map_valid_nxt;

  logic [15:0] dec;
  logic [7:0]  prg_bank, chr_bank;
  logic [7:0]  pair_lo, pair_hi;

  // input holding register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      addr_r  <= in_address;
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r <= 8'hFF;
      chr_mask_r <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRG_MASK: prg_mask_r <= cfg_wdata;
        REG_CHR_MASK: chr_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dec      = addr_r & DECODE_MASK;
  assign pair_lo  = value_r & 8'hFE;
  assign pair_hi  = value_r | 8'h01;
  assign prg_bank = prg_bank_r[addr_r[14:13]] & prg_mask_r;
  assign chr_bank = chr_bank_r[addr_r[12:10]] & chr_mask_r;

  always_comb begin
    command_nxt   = command_r;
    prg_bank_nxt  = prg_bank_r;
    chr_bank_nxt  = chr_bank_r;
    map_addr_nxt  = '0;
    map_valid_nxt = 1'b0;
    case (mode_r)
      MODE_BUS_WRITE: begin
        if (dec == ADDR_COMMAND) begin
          command_nxt = value_r;
        end else if (dec == ADDR_DATA) begin
          case (command_r)
            CMD_CHR01_PAIR: begin
              chr_bank_nxt[0] = pair_lo;
              chr_bank_nxt[1] = pair_hi;
            end
            CMD_CHR23_PAIR: begin
              chr_bank_nxt[2] = pair_lo;
              chr_bank_nxt[3] = pair_hi;
            end
            CMD_CHR45_PAIR: begin
              chr_bank_nxt[4] = pair_lo;
              chr_bank_nxt[5] = pair_hi;
            end
            CMD_CHR67_PAIR: begin
              chr_bank_nxt[6] = pair_lo;
              chr_bank_nxt[7] = pair_hi;
            end
            CMD_CHR0:     chr_bank_nxt[0] = value_r;
            CMD_CHR1:     chr_bank_nxt[1] = value_r;
            CMD_CHR2:     chr_bank_nxt[2] = value_r;
            CMD_CHR3:     chr_bank_nxt[3] = value_r;
            CMD_CHR4:     chr_bank_nxt[4] = value_r;
            CMD_CHR5:     chr_bank_nxt[5] = value_r;
            CMD_CHR6:     chr_bank_nxt[6] = value_r;
            CMD_CHR7:     chr_bank_nxt[7] = value_r;
            CMD_PRG0:     prg_bank_nxt[0] = value_r;
            CMD_PRG1:     prg_bank_nxt[1] = value_r;
            CMD_PRG1_ALT: prg_bank_nxt[1] = value_r;
            CMD_PRG2_ALT: prg_bank_nxt[2] = value_r;
            default: ;
          endcase
        end
      end
      MODE_PRG_XLATE: begin
        if (addr_r >= PRG_BASE) begin
          map_addr_nxt  = {prg_bank, addr_r[12:0]};
          map_valid_nxt = 1'b1;
        end
      end
      MODE_CHR_XLATE: begin
        if (addr_r < CHR_LIMIT) begin
          map_addr_nxt  = {3'b000, chr_bank, addr_r[9:0]};
          map_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r     <= 8'h00;
      prg_bank_r[0] <= 8'h00;
      prg_bank_r[1] <= 8'h01;
      prg_bank_r[2] <= 8'hFE;
      prg_bank_r[3] <= 8'hFF;
      for (int i = 0; i < CHR_WINDOWS; i++) begin
        chr_bank_r[i] <= 8'(i);
      end
    end else if (cmd.execute) begin
      command_r  <= command_nxt;
      prg_bank_r <= prg_bank_nxt;
      chr_bank_r <= chr_bank_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      map_addr_r  <= map_addr_nxt;
      map_valid_r <= map_valid_nxt;
    end
  end

  assign mapped_address = map_addr_r;
  assign mapped_valid   = map_valid_r;

endmodule

// ===== hw/rtl/bank_switch_register_mapper.sv =====
`timescale 1ns / 1ps
// Bank-switch register mapper: bus writes load command/bank registers, translates map addresses.
// Each input is captured into the holding register, then executed into the result register once free.
// A new input is taken only after the previous one has been executed into the result register.
// A new input is taken while a finished result still waits on the output register.
// Reset (rst_n low, synchronous): masks 0xFF, command 0, prg banks 0,1,FE,FF, chr banks 0..7.

module bank_switch_register_mapper (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] mapped_address, [23:21] zero
  output logic        out_tuser,  // [0] mapped_valid
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import bsrm_pkg::*;

  ctrl_cmd_t   cmd;
  logic [20:0] mapped_address;
  logic        mapped_valid;

  // Controller: sequences capture and execute, owns the output valid flag.
  bsrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Datapath: bank registers, command decode, translation and result register.
  bsrm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_tuser),
    .in_address     (in_tdata[15:0]),
    .in_value       (in_tdata[23:16]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mapped_address (mapped_address),
    .mapped_valid   (mapped_valid)
  );

  // pad result to whole bytes
  assign out_tdata = {3'b000, mapped_address};
  assign out_tuser = mapped_valid;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bsrm_pkg::*;

  // Index values outside the register file; the block must ignore writes to them
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all before giving up
  localparam int LONG_HOLD    = 300;   // receiver hold-off used to back the block up
  localparam int PHASE_ITEMS  = 218;
  localparam int DRAIN_CYCLES = 4;     // margin for the block to settle after the last result

  // One translate result: address in bits [21:1], window hit in bit [0]
  typedef struct packed {
    logic [20:0] mapped_address;
    logic        mapped_valid;
  } xlate_t;

  // Mirrors the mapper state and holds the translate results still owed by the block
  class bank_map_scoreboard;
    logic [7:0] prg_mask;
    logic [7:0] chr_mask;
    logic [7:0] command;
    logic [7:0] prg_bank [PRG_WINDOWS];
    logic [7:0] chr_bank [CHR_WINDOWS];
    xlate_t     owed_q [$];
    int         errors;

    function void reset_state();
      prg_mask = 8'hFF;
      chr_mask = 8'hFF;
      command  = CMD_CHR01_PAIR;
      prg_bank[0] = 8'h00;
      prg_bank[1] = 8'h01;
      prg_bank[2] = 8'hFE;
      prg_bank[3] = 8'hFF;
      for (int i = 0; i < CHR_WINDOWS; i++) chr_bank[i] = 8'(i);
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == REG_PRG_MASK) prg_mask = data;
      else if (idx == REG_CHR_MASK) chr_mask = data;
    endfunction

    function void set_chr_pair(int first, logic [7:0] v);
      chr_bank[first]     = v & 8'hFE;
      chr_bank[first + 1] = v | 8'h01;
    endfunction

    // Data write: the latched command picks the bank register(s)
    function void load_bank(logic [7:0] v);
      case (command)
        CMD_CHR01_PAIR: set_chr_pair(0, v);
        CMD_CHR23_PAIR: set_chr_pair(2, v);
        CMD_CHR4:       chr_bank[4] = v;
        CMD_CHR5:       chr_bank[5] = v;
        CMD_CHR6:       chr_bank[6] = v;
        CMD_CHR7:       chr_bank[7] = v;
        CMD_PRG0:       prg_bank[0] = v;
        CMD_PRG1:       prg_bank[1] = v;
        CMD_PRG2_ALT:   prg_bank[2] = v;
        CMD_PRG1_ALT:   prg_bank[1] = v;
        CMD_CHR45_PAIR: set_chr_pair(4, v);
        CMD_CHR67_PAIR: set_chr_pair(6, v);
        CMD_CHR0:       chr_bank[0] = v;
        CMD_CHR1:       chr_bank[1] = v;
        CMD_CHR2:       chr_bank[2] = v;
        CMD_CHR3:       chr_bank[3] = v;
        default: ;
      endcase
    endfunction

    function void note_transfer(logic [1:0] mode, logic [15:0] addr, logic [7:0] value);
      xlate_t     res;
      logic [7:0] bank;
      res = '0;
      case (mode)
        MODE_BUS_WRITE: begin
          if ((addr & DECODE_MASK) == ADDR_COMMAND) command = value;
          else if ((addr & DECODE_MASK) == ADDR_DATA) load_bank(value);
        end
        MODE_PRG_XLATE: begin
          if (addr >= PRG_BASE) begin
            bank = prg_bank[addr[14:13]] & prg_mask;
            res.mapped_address = {bank, addr[12:0]};
            res.mapped_valid   = 1'b1;
          end
        end
        MODE_CHR_XLATE: begin
          if (addr < CHR_LIMIT) begin
            bank = chr_bank[addr[12:10]] & chr_mask;
            res.mapped_address = {3'b000, bank, addr[9:0]};
            res.mapped_valid   = 1'b1;
          end
        end
        default: ;  // unused mode: no state change, zero result
      endcase
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [20:0] mapped_address, logic mapped_valid);
      xlate_t exp_res;
      if (owed_q.size() == 0) begin
        $error("result with nothing outstanding: mapped_address %06h mapped_valid %0d",
               mapped_address, mapped_valid);
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (mapped_address !== exp_res.mapped_address) begin
        $error("mapped_address: expected %06h, got %06h",
               exp_res.mapped_address, mapped_address);
        errors++;
      end
      if (mapped_valid !== exp_res.mapped_valid) begin
        $error("mapped_valid: expected %0d, got %0d", exp_res.mapped_valid, mapped_valid);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [15:0] address, [23:16] value
  logic [1:0]  in_tuser;    // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [20:0] mapped_address, [23:21] zero
  logic        out_tuser;   // [0] mapped_valid
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  bank_map_scoreboard sb;

  // Knobs shared by the driver processes
  bit tx_gaps;     // sender inserts idle bursts
  bit rx_stalls;   // receiver inserts stall bursts
  bit hold_req;    // receiver should hold off for LONG_HOLD cycles
  int quiet_cycles;

  bank_switch_register_mapper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitors: everything sampled at the rising edge, before the block's own updates land.
  // A result can never belong to an input taken at the same edge, so the
  // order of the two checks below does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_transfer(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[20:0], out_tuser);
      // watchdog: any transfer on any port counts as progress
      if (cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Result-side ready: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 6) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // tvalid stays high between back-to-back items.
  task automatic send_item(logic [1:0] mode, logic [15:0] addr, logic [7:0] value);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {value, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_listed_command();
    case ($urandom_range(0, 15))
      0:  return CMD_CHR01_PAIR;
      1:  return CMD_CHR23_PAIR;
      2:  return CMD_CHR4;
      3:  return CMD_CHR5;
      4:  return CMD_CHR6;
      5:  return CMD_CHR7;
      6:  return CMD_PRG0;
      7:  return CMD_PRG1;
      8:  return CMD_PRG2_ALT;
      9:  return CMD_PRG1_ALT;
      10: return CMD_CHR45_PAIR;
      11: return CMD_CHR67_PAIR;
      12: return CMD_CHR0;
      13: return CMD_CHR1;
      14: return CMD_CHR2;
      default: return CMD_CHR3;
    endcase
  endfunction

  // Decoded aliases: only bits 15:13 and 0 matter to the decoder
  function automatic logic [15:0] command_alias();
    return {3'b100, 12'($urandom), 1'b0};
  endfunction

  function automatic logic [15:0] data_alias();
    return {3'b100, 12'($urandom), 1'b1};
  endfunction

  task automatic send_translate();
    logic [15:0] addr;
    addr = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 6) != 0) addr[15] = 1'b1;      // mostly inside the program window
      send_item(MODE_PRG_XLATE, addr, 8'($urandom));
    end else begin
      if ($urandom_range(0, 6) != 0) addr[15:13] = 3'b000; // mostly inside the pattern window
      send_item(MODE_CHR_XLATE, addr, 8'($urandom));
    end
  endtask

  // Mostly well-formed command/data pairs and translates, some noise
  task automatic run_random(int n_items);
    int         sent;
    int         pick;
    logic [7:0] cmd;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        cmd = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_listed_command();
        send_item(MODE_BUS_WRITE, command_alias(), cmd);
        if ($urandom_range(0, 9) == 0) begin
          send_translate();
          sent++;
        end
        send_item(MODE_BUS_WRITE, data_alias(), 8'($urandom));
        sent += 2;
      end else if (pick < 85) begin
        send_translate();
        sent++;
      end else begin
        send_item(2'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Field extremes, window edges, decode aliases and the do-nothing cases
  task automatic run_directed();
    send_item(MODE_PRG_XLATE, 16'h8000, 8'h00);
    send_item(MODE_PRG_XLATE, 16'hFFFF, 8'hFF);
    send_item(MODE_PRG_XLATE, 16'h7FFF, 8'h00);  // just below the program window
    send_item(MODE_PRG_XLATE, 16'hA123, 8'hFF);  // value ignored on translate
    send_item(MODE_CHR_XLATE, 16'h0000, 8'hFF);
    send_item(MODE_CHR_XLATE, 16'h1FFF, 8'h00);
    send_item(MODE_CHR_XLATE, 16'h2000, 8'h00);  // just past the pattern window
    send_item(2'b11, 16'hFFFF, 8'hFF);           // unused mode
    send_item(2'b11, 16'h0000, 8'h00);
    send_item(MODE_BUS_WRITE, ADDR_COMMAND, CMD_PRG0);
    send_item(MODE_BUS_WRITE, 16'h9FFF, 8'hA5);  // data alias
    send_item(MODE_PRG_XLATE, 16'h8000, 8'h00);
    send_item(MODE_BUS_WRITE, 16'h9FFE, CMD_CHR45_PAIR);  // command alias
    send_item(MODE_BUS_WRITE, ADDR_DATA, 8'hFF);
    send_item(MODE_CHR_XLATE, 16'h1000, 8'h00);
    send_item(MODE_CHR_XLATE, 16'h1400, 8'h00);
    send_item(MODE_BUS_WRITE, 16'hA000, 8'h00);  // undecoded
    send_item(MODE_BUS_WRITE, 16'h0001, 8'h00);  // undecoded
    send_item(MODE_BUS_WRITE, ADDR_COMMAND, 8'h08);  // command with no bank behind it
    send_item(MODE_BUS_WRITE, ADDR_DATA, 8'h33);
    send_item(MODE_CHR_XLATE, 16'h03FF, 8'h00);
    send_item(MODE_BUS_WRITE, ADDR_COMMAND, CMD_PRG2_ALT);
    send_item(MODE_BUS_WRITE, ADDR_DATA, 8'h00);
    send_item(MODE_PRG_XLATE, 16'hC000, 8'h00);
    send_item(MODE_BUS_WRITE, ADDR_COMMAND, CMD_CHR0);
    send_item(MODE_BUS_WRITE, ADDR_DATA, 8'h00);
    send_item(MODE_CHR_XLATE, 16'h0000, 8'h00);
  endtask

  initial begin
    sb = new;
    sb.reset_state();
    quiet_cycles = 0;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_BUS_WRITE;
    cfg_we       = 1'b0;
    cfg_index    = REG_PRG_MASK;
    cfg_wdata    = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset masks (all ones) in effect here
    run_directed();
    drain();

    // writes to unused indexes must not disturb anything; masks fully closed
    write_reg(REG_SPARE_A, 8'h00);
    write_reg(REG_SPARE_B, 8'h55);
    write_reg(REG_PRG_MASK, 8'h00);
    write_reg(REG_CHR_MASK, 8'h00);
    run_random(PHASE_ITEMS);
    drain();

    // typical cartridge sizes; receiver backs the block up at the start
    write_reg(REG_PRG_MASK, 8'h1F);
    write_reg(REG_CHR_MASK, 8'h7F);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(REG_PRG_MASK, 8'($urandom));
    write_reg(REG_CHR_MASK, 8'($urandom));
    run_random(PHASE_ITEMS);
    drain();

    // last stretch at full rate on both sides
    write_reg(REG_PRG_MASK, 8'hFF);
    write_reg(REG_CHR_MASK, 8'hFF);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_random(PHASE_ITEMS);
    drain();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bsrm_pkg.sv
hw/rtl/bsrm_ctrl.sv
hw/rtl/bsrm_datapath.sv
hw/rtl/bank_switch_register_mapper.sv
test/tb.sv
